/* rtl/andys_pkg.sv */
// Package for the active network dyad statistics block.
// Holds sizes, register and statistic codes, controller types and shared functions.
// No dependencies.
package andys_pkg;

    localparam int NUM_ACTORS = 64;
    localparam int COUNT_BITS = 16;
    localparam int ACTOR_BITS = $clog2(NUM_ACTORS);
    localparam int PAIR_BITS  = 2 * ACTOR_BITS;
    localparam int PAIR_DEPTH = 1 << PAIR_BITS;
    localparam int IN_W       = 6;
    localparam int KIND_W     = 4;
    localparam int OUT_W      = 17;
    localparam int SUM_W      = (COUNT_BITS + 1 > OUT_W) ? COUNT_BITS + 1 : OUT_W;
    localparam int SP_W       = ACTOR_BITS + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_STAT_KIND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED  = 1'b1;

    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [KIND_W-1:0] KIND_TIE    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_OUT_A  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_IN_B   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DEG_A  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_DEG_B  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_OTP    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_ITP    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_OSP    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_ISP    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_U_DEGA = 4'd2;
    localparam logic [KIND_W-1:0] KIND_U_DEGB = 4'd3;
    localparam logic [KIND_W-1:0] KIND_U_SP   = 4'd4;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_EV_RD, ST_EV_WR, ST_EV_RD2, ST_EV_WR2,
        ST_Q_RD, ST_Q_CAP, ST_SP_RUN, ST_SP_LAST, ST_SP_CAP, ST_DONE
    } state_t;

    typedef enum logic [1:0] {RD_EV, RD_EV2, RD_Q, RD_SP} rd_sel_t;
    typedef enum logic [1:0] {WR_NONE, WR_CLR, WR_EV, WR_EV2} wr_sel_t;
    typedef enum logic [1:0] {CAP_NONE, CAP_ZERO, CAP_STAT, CAP_SP} cap_sel_t;

    typedef struct packed {
        logic     latch;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        cap_sel_t cap_sel;
        logic     sp_start;
        logic     sp_issue;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic ok;
        logic bad_query;
        logic is_sp;
        logic directed;
        logic sp_last;
        logic clr_last;
        logic out_free;
    } status_t;

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c,
                                                   input logic down);
        logic [COUNT_BITS-1:0] r;
        r = c;
        if (down)
        begin
            if (c != '0)
                r = c - 1'b1;
        end
        else if (c != '1)
        begin
            r = c + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [PAIR_BITS-1:0] canon(input logic [ACTOR_BITS-1:0] x,
                                                   input logic [ACTOR_BITS-1:0] y);
        return (x < y) ? {x, y} : {y, x};
    endfunction

endpackage

/* rtl/andys_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module andys_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/andys_ctrl.sv */
// Controller state machine of the dyad statistics block.
// Depends on andys_pkg; drives the datapath by commands and reads its status.
module andys_ctrl
    import andys_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:    if (in_valid) state_next = ST_DECODE;
            ST_DECODE:
            begin
                if (!status.is_query)
                    state_next = status.ok ? ST_EV_RD : ST_IDLE;
                else if (status.bad_query)
                    state_next = ST_DONE;
                else if (status.is_sp)
                    state_next = ST_SP_RUN;
                else
                    state_next = ST_Q_RD;
            end
            ST_EV_RD:   state_next = ST_EV_WR;
            ST_EV_WR:   state_next = status.directed ? ST_IDLE : ST_EV_RD2;
            ST_EV_RD2:  state_next = ST_EV_WR2;
            ST_EV_WR2:  state_next = ST_IDLE;
            ST_Q_RD:    state_next = ST_Q_CAP;
            ST_Q_CAP:   state_next = ST_DONE;
            ST_SP_RUN:  if (status.sp_last) state_next = ST_SP_LAST;
            ST_SP_LAST: state_next = ST_SP_CAP;
            ST_SP_CAP:  state_next = ST_DONE;
            ST_DONE:    if (status.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.rd_sel   = RD_Q;
        cmd.wr_sel   = WR_NONE;
        cmd.cap_sel  = CAP_NONE;
        in_stall     = 1'b1;
        case (state_reg)
            ST_CLEAR:   cmd.wr_sel = WR_CLR;
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.latch = in_valid;
            end
            ST_DECODE:
            begin
                if (status.is_query && status.bad_query)
                    cmd.cap_sel = CAP_ZERO;
                cmd.sp_start = 1'b1;
            end
            ST_EV_RD:   cmd.rd_sel = RD_EV;
            ST_EV_WR:   cmd.wr_sel = WR_EV;
            ST_EV_RD2:  cmd.rd_sel = RD_EV2;
            ST_EV_WR2:  cmd.wr_sel = WR_EV2;
            ST_Q_RD:    cmd.rd_sel = RD_Q;
            ST_Q_CAP:   cmd.cap_sel = CAP_STAT;
            ST_SP_RUN:
            begin
                cmd.rd_sel   = RD_SP;
                cmd.sp_issue = 1'b1;
            end
            ST_SP_LAST: cmd.rd_sel = RD_SP;
            ST_SP_CAP:  cmd.cap_sel = CAP_SP;
            ST_DONE:    cmd.out_load = status.out_free;
            default:    cmd.rd_sel = RD_Q;
        endcase
    end

endmodule

/* rtl/andys_dp.sv */
// Datapath of the dyad statistics block: stores, address selection, counters,
// statistic arithmetic and the output register. Depends on andys_pkg and andys_ram.
module andys_dp
    import andys_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  op,
    input  logic [IN_W-1:0]       actor_a,
    input  logic [IN_W-1:0]       actor_b,
    input  logic                  ends,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_W-1:0]      stat_value
);

    logic [KIND_W-1:0]     kind_reg;
    logic                  dir_reg;
    logic                  op_reg;
    logic [IN_W-1:0]       a_reg;
    logic [IN_W-1:0]       b_reg;
    logic                  ends_reg;
    logic [PAIR_BITS-1:0]  clr_reg;
    logic [ACTOR_BITS-1:0] h_reg;
    logic [ACTOR_BITS-1:0] hd_reg;
    logic                  spv_reg;
    logic [SP_W-1:0]       acc_reg;
    logic [OUT_W-1:0]      val_reg;
    logic [OUT_W-1:0]      val_next;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      stat_value_reg;

    logic [ACTOR_BITS-1:0] ai;
    logic [ACTOR_BITS-1:0] bi;
    logic                  ok;
    logic [PAIR_BITS-1:0]  p_ev;
    logic [PAIR_BITS-1:0]  p0_raddr, p1_raddr, p_waddr;
    logic [ACTOR_BITS-1:0] o_raddr, i_raddr, o_waddr, i_waddr;
    logic                  p_we, o_we, i_we;
    logic [COUNT_BITS-1:0] p_wdata, o_wdata, i_wdata;
    logic [COUNT_BITS-1:0] p0_rd, p1_rd, o_rd, i_rd;
    logic                  kind_ok, is_sp, hit;
    logic [SUM_W-1:0]      sum, stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_TIE;
            dir_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_STAT_KIND)
                kind_reg <= cfg_data;
            else if (cfg_index == CFG_DIRECTED)
                dir_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= op;
            a_reg    <= actor_a;
            b_reg    <= actor_b;
            ends_reg <= ends;
        end
    end

    assign ai = ACTOR_BITS'(a_reg);
    assign bi = ACTOR_BITS'(b_reg);
    assign ok = (32'(a_reg) < NUM_ACTORS) && (32'(b_reg) < NUM_ACTORS);
    assign p_ev = dir_reg ? {ai, bi} : canon(ai, bi);

    always_comb
    begin
        if (dir_reg)
        begin
            kind_ok = (kind_reg >= KIND_TIE) && (kind_reg <= KIND_ISP);
            is_sp   = (kind_reg >= KIND_OTP) && (kind_reg <= KIND_ISP);
        end
        else
        begin
            kind_ok = (kind_reg >= KIND_TIE) && (kind_reg <= KIND_U_SP);
            is_sp   = (kind_reg == KIND_U_SP);
        end
    end

    always_comb
    begin
        p0_raddr = p_ev;
        p1_raddr = p_ev;
        o_raddr  = ai;
        i_raddr  = bi;
        case (cmd.rd_sel)
            RD_EV:  o_raddr = ai;
            RD_EV2: o_raddr = bi;
            RD_Q:
            begin
                o_raddr = ((dir_reg && kind_reg == KIND_DEG_B)
                           || (!dir_reg && kind_reg == KIND_U_DEGB)) ? bi : ai;
                i_raddr = (kind_reg == KIND_IN_B || kind_reg == KIND_DEG_B) ? bi : ai;
            end
            RD_SP:
            begin
                if (!dir_reg)
                begin
                    p0_raddr = canon(ai, h_reg);
                    p1_raddr = canon(bi, h_reg);
                end
                else
                begin
                    case (kind_reg)
                        KIND_OTP:
                        begin
                            p0_raddr = {ai, h_reg};
                            p1_raddr = {h_reg, bi};
                        end
                        KIND_ITP:
                        begin
                            p0_raddr = {bi, h_reg};
                            p1_raddr = {h_reg, ai};
                        end
                        KIND_OSP:
                        begin
                            p0_raddr = {ai, h_reg};
                            p1_raddr = {bi, h_reg};
                        end
                        default:
                        begin
                            p0_raddr = {h_reg, ai};
                            p1_raddr = {h_reg, bi};
                        end
                    endcase
                end
            end
            default: o_raddr = ai;
        endcase
    end

    always_comb
    begin
        p_we    = 1'b0;
        o_we    = 1'b0;
        i_we    = 1'b0;
        p_waddr = p_ev;
        o_waddr = ai;
        i_waddr = bi;
        p_wdata = bump(p0_rd, ends_reg);
        o_wdata = bump(o_rd, ends_reg);
        i_wdata = bump(i_rd, ends_reg);
        case (cmd.wr_sel)
            WR_CLR:
            begin
                p_we    = 1'b1;
                o_we    = 1'b1;
                i_we    = 1'b1;
                p_waddr = clr_reg;
                o_waddr = clr_reg[ACTOR_BITS-1:0];
                i_waddr = clr_reg[ACTOR_BITS-1:0];
                p_wdata = '0;
                o_wdata = '0;
                i_wdata = '0;
            end
            WR_EV:
            begin
                p_we = 1'b1;
                o_we = 1'b1;
                i_we = dir_reg;
            end
            WR_EV2:
            begin
                o_we    = 1'b1;
                o_waddr = bi;
            end
            default: p_we = 1'b0;
        endcase
    end

    andys_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_pair0 (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p0_raddr), .rdata(p0_rd)
    );

    andys_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_pair1 (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p1_raddr), .rdata(p1_rd)
    );

    andys_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_ACTORS)) u_out (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rd)
    );

    andys_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_ACTORS)) u_in (
        .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
        .raddr(i_raddr), .rdata(i_rd)
    );

    assign hit = (p0_rd != '0) && (p1_rd != '0) && (hd_reg != ai) && (hd_reg != bi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            spv_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_sel == WR_CLR)
                clr_reg <= clr_reg + 1'b1;
            spv_reg <= cmd.sp_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sp_start)
        begin
            h_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (cmd.sp_issue)
                h_reg <= h_reg + 1'b1;
            if (spv_reg && hit)
                acc_reg <= acc_reg + 1'b1;
        end
        hd_reg <= h_reg;
    end

    always_comb
    begin
        sum  = SUM_W'(o_rd) + SUM_W'(i_rd);
        stat = '0;
        if (dir_reg)
        begin
            case (kind_reg)
                KIND_TIE:   stat = SUM_W'(p0_rd != '0);
                KIND_OUT_A: stat = SUM_W'(o_rd);
                KIND_IN_B:  stat = SUM_W'(i_rd);
                KIND_DEG_A,
                KIND_DEG_B: stat = sum;
                default:    stat = '0;
            endcase
        end
        else
        begin
            case (kind_reg)
                KIND_TIE:    stat = SUM_W'(p0_rd != '0);
                KIND_U_DEGA,
                KIND_U_DEGB: stat = SUM_W'(o_rd);
                default:     stat = '0;
            endcase
        end
    end

    always_comb
    begin
        val_next = val_reg;
        case (cmd.cap_sel)
            CAP_ZERO: val_next = '0;
            CAP_STAT: val_next = (stat > SUM_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(stat);
            CAP_SP:   val_next = OUT_W'(acc_reg);
            default:  val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (cmd.out_load)
            stat_value_reg <= val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid  = out_valid_reg;
    assign stat_value = stat_value_reg;

    assign status.is_query  = (op_reg == OP_QUERY);
    assign status.ok        = ok;
    assign status.bad_query = !ok || (a_reg == b_reg) || !kind_ok;
    assign status.is_sp     = is_sp;
    assign status.directed  = dir_reg;
    assign status.sp_last   = (h_reg == ACTOR_BITS'(NUM_ACTORS - 1));
    assign status.clr_last  = (clr_reg == '1);
    assign status.out_free  = !out_valid_reg || !out_stall;

endmodule

/* rtl/active_network_dyad_stats.sv */
// Top level of the active network dyad statistics block.
// Depends on andys_pkg, andys_ctrl and andys_dp.
//
// Usage:
// The input channel carries one item per beat: an event (op 0) that starts or
// ends an interaction from actor_a to actor_b, or a query (op 1) for a pair.
// Only queries produce an output beat, carrying stat_value for the statistic
// chosen by the stat_kind register; directed_mode picks ordered or unordered pairs.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// do so only while idle, as the block does not enforce it. One item is processed
// at a time. An event reads its counts and writes them back; in undirected mode a
// second read and write updates actor_b. A degree or tie query reads the stores
// and shows its result; a shared-partner query walks all 64 partner actors, one
// per cycle through two copies of the pair store. After reset the block clears its
// stores, one pair entry per cycle; in_stall stays high during that pass.
// The output beat sits in a register; while the receiver stalls it holds,
// and the block can accept the next item, but a later query waits until the
// output register is free.
module active_network_dyad_stats
    import andys_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [IN_W-1:0]       actor_a,
    input  logic [IN_W-1:0]       actor_b,
    input  logic                  ends,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_W-1:0]      stat_value,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    andys_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    andys_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .actor_a    (actor_a),
        .actor_b    (actor_b),
        .ends       (ends),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .stat_value (stat_value)
    );

`ifndef SYNTHESIS
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_CLR) |-> in_stall)
        else $error("Input accepted during the clearing pass.");

    a_event_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op == OP_EVENT) |=> !$rose(out_valid))
        else $error("An event produced a result beat.");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("Output register overwritten while stalled.");
`endif

endmodule
